>>> hdl/cbf_pkg.sv
// Shared types and constants of the circuit breaker.
package cbf_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_SUCCESS = 2'd1;
  localparam logic [1:0] CMD_FAILURE = 2'd2;

  localparam logic [2:0] REG_FAILURE_LIMIT = 3'd0;
  localparam logic [2:0] REG_WINDOW_MS     = 3'd1;
  localparam logic [2:0] REG_RATE_LIMIT    = 3'd2;
  localparam logic [2:0] REG_OPEN_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_PROBE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_RECOVERY      = 3'd5;

  typedef enum logic [1:0] {
    BRK_CLOSED = 2'd0,
    BRK_OPEN   = 2'd1,
    BRK_HALF   = 2'd2
  } brk_state_e;

  typedef struct packed {
    logic [15:0] failure_limit;
    logic [31:0] window_ms;
    logic [8:0]  rate_limit_q8;
    logic [31:0] open_hold_ms;
    logic [7:0]  probe_limit;
    logic [15:0] recovery_successes;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic probe_first;
    logic inc_probes;
    logic clr_probes;
    logic inc_success;
    logic clr_success;
    logic clr_failure;
    logic push_failure;
    logic scan_start;
    logic set_changed;
  } dp_cmd_t;

  typedef struct packed {
    logic timeout;
    logic probe_ok;
    logic probe_lim_nz;
    logic succ_done;
    logic fail_lim;
    logic scan_done;
    logic rate_trip;
  } dp_stat_t;

endpackage

>>> hdl/cbf_if.sv
// Request and result channel interfaces of the circuit breaker.
interface cbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [47:0] now_ms;

  modport source (output valid, output command, output now_ms, input ready);
  modport sink (input valid, input command, input now_ms, output ready);
endinterface

interface cbf_out_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] circuit_state;
  logic       state_changed;
  logic       tripped;

  modport source (output valid, output allowed, output circuit_state, output state_changed,
                  output tripped, input ready);
  modport sink (input valid, input allowed, input circuit_state, input state_changed,
                input tripped, output ready);
endinterface

>>> hdl/cbf_regs.sv
// APB configuration registers of the circuit breaker.
module cbf_regs import cbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel_i && penable_i && pwrite_i;
  assign idx   = paddr_i[4:2];
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_limit      <= 16'd5;
      cfg_q.window_ms          <= 32'd60000;
      cfg_q.rate_limit_q8      <= 9'd128;
      cfg_q.open_hold_ms       <= 32'd30000;
      cfg_q.probe_limit        <= 8'd3;
      cfg_q.recovery_successes <= 16'd2;
    end else if (wr_en) begin
      unique case (idx)
        REG_FAILURE_LIMIT: cfg_q.failure_limit      <= pwdata_i[15:0];
        REG_WINDOW_MS:     cfg_q.window_ms          <= pwdata_i;
        REG_RATE_LIMIT:    cfg_q.rate_limit_q8      <= pwdata_i[8:0];
        REG_OPEN_TIMEOUT:  cfg_q.open_hold_ms       <= pwdata_i;
        REG_PROBE_LIMIT:   cfg_q.probe_limit        <= pwdata_i[7:0];
        REG_RECOVERY:      cfg_q.recovery_successes <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FAILURE_LIMIT: prdata_o = {16'h0, cfg_q.failure_limit};
      REG_WINDOW_MS:     prdata_o = cfg_q.window_ms;
      REG_RATE_LIMIT:    prdata_o = {23'h0, cfg_q.rate_limit_q8};
      REG_OPEN_TIMEOUT:  prdata_o = cfg_q.open_hold_ms;
      REG_PROBE_LIMIT:   prdata_o = {24'h0, cfg_q.probe_limit};
      REG_RECOVERY:      prdata_o = {16'h0, cfg_q.recovery_successes};
      default:           prdata_o = '0;
    endcase
  end

endmodule

>>> hdl/cbf_datapath.sv
// Counters, failure history memory and windowed rate scan of the circuit breaker.
module cbf_datapath import cbf_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [TIME_W-1:0] now_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o
);

  localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TW = ((FW > 16) ? FW : 16) + 1;
  localparam int unsigned PW = 9 + TW;

  function automatic logic [15:0] sat_inc16(input logic [15:0] x);
    sat_inc16 = (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  logic [TIME_W-1:0] mem [HISTORY_DEPTH];

  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] changed_at_q;
  logic [15:0]       fail_q;
  logic [15:0]       succ_q;
  logic [7:0]        probes_q;
  logic [HW-1:0]     head_q;
  logic [FW-1:0]     fill_q;

  logic              issuing_q;
  logic [HW-1:0]     idx_q;
  logic              data_v_q;
  logic              last_q;
  logic              sum_v_q;
  logic              mul_v_q;
  logic [FW-1:0]     recent_q;
  logic [TIME_W-1:0] rd_data_q;
  logic [TIME_W-1:0] wstart_q;
  logic [PW-1:0]     lhs_q;
  logic [PW-1:0]     prod_q;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] window_ext;
  logic [FW-1:0]     fill_m1;
  logic [HW-1:0]     last_idx;
  logic [TW-1:0]     total;
  logic [PW-1:0]     prod_w;
  logic              hit;

  assign elapsed    = now_q - changed_at_q;
  assign window_ext = {16'h0, cfg_i.window_ms};
  assign fill_m1    = fill_q - FW'(1);
  assign last_idx   = fill_m1[HW-1:0];
  assign total      = TW'(recent_q) + TW'(succ_q);
  assign prod_w     = cfg_i.rate_limit_q8 * total;
  assign hit        = (rd_data_q >= wstart_q);

  assign stat_o.timeout      = (elapsed >= {16'h0, cfg_i.open_hold_ms});
  assign stat_o.probe_ok     = (probes_q < cfg_i.probe_limit);
  assign stat_o.probe_lim_nz = (cfg_i.probe_limit != 8'd0);
  assign stat_o.succ_done    = (sat_inc16(succ_q) >= cfg_i.recovery_successes);
  assign stat_o.fail_lim     = (sat_inc16(fail_q) >= cfg_i.failure_limit);
  assign stat_o.scan_done    = mul_v_q;
  assign stat_o.rate_trip    = (lhs_q >= prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_at_q <= '0;
      fail_q       <= '0;
      succ_q       <= '0;
      probes_q     <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      issuing_q    <= 1'b0;
      idx_q        <= '0;
      data_v_q     <= 1'b0;
      last_q       <= 1'b0;
      sum_v_q      <= 1'b0;
      mul_v_q      <= 1'b0;
      recent_q     <= '0;
    end else begin
      if (cmd_i.set_changed) begin
        changed_at_q <= now_q;
      end
      if (cmd_i.clr_failure) begin
        fail_q <= '0;
      end else if (cmd_i.push_failure) begin
        fail_q <= sat_inc16(fail_q);
      end
      if (cmd_i.clr_success) begin
        succ_q <= '0;
      end else if (cmd_i.inc_success) begin
        succ_q <= sat_inc16(succ_q);
      end
      if (cmd_i.probe_first) begin
        probes_q <= stat_o.probe_lim_nz ? 8'd1 : 8'd0;
      end else if (cmd_i.clr_probes) begin
        probes_q <= '0;
      end else if (cmd_i.inc_probes && probes_q != 8'hFF) begin
        probes_q <= probes_q + 8'd1;
      end
      if (cmd_i.push_failure) begin
        head_q <= (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + HW'(1);
        if (fill_q != FW'(HISTORY_DEPTH)) begin
          fill_q <= fill_q + FW'(1);
        end
      end

      if (cmd_i.scan_start) begin
        issuing_q <= 1'b1;
        idx_q     <= '0;
        recent_q  <= '0;
      end else if (issuing_q) begin
        idx_q <= idx_q + HW'(1);
        if (idx_q == last_idx) begin
          issuing_q <= 1'b0;
        end
      end
      data_v_q <= issuing_q;
      last_q   <= issuing_q && (idx_q == last_idx);
      if (data_v_q && hit) begin
        recent_q <= recent_q + FW'(1);
      end
      sum_v_q <= data_v_q && last_q;
      mul_v_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= now_i;
    end
    if (cmd_i.scan_start) begin
      wstart_q <= (now_q >= window_ext) ? now_q - window_ext : '0;
    end
    if (sum_v_q) begin
      lhs_q  <= PW'({recent_q, 8'h00});
      prod_q <= prod_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_failure) begin
      mem[head_q] <= now_q;
    end
    if (issuing_q) begin
      rd_data_q <= mem[idx_q];
    end
  end

endmodule

>>> hdl/cbf_ctrl.sv
// Breaker state machine and result register of the circuit breaker.
module cbf_ctrl import cbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_command_i,
  output dp_cmd_t    dp_cmd_o,
  input  dp_stat_t   dp_stat_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       allowed_o,
  output logic [1:0] circuit_state_o,
  output logic       state_changed_o,
  output logic       tripped_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_OUT
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  brk_state_e  brk_q, brk_d;
  logic [1:0]  cmd_q, cmd_d;
  logic        res_allowed_q, res_allowed_d;
  logic        res_changed_q, res_changed_d;
  logic        res_tripped_q, res_tripped_d;
  logic        out_valid_q, out_valid_d;
  logic        out_allowed_q, out_allowed_d;
  brk_state_e  out_state_q, out_state_d;
  logic        out_changed_q, out_changed_d;
  logic        out_tripped_q, out_tripped_d;

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign allowed_o       = out_allowed_q;
  assign circuit_state_o = out_state_q;
  assign state_changed_o = out_changed_q;
  assign tripped_o       = out_tripped_q;

  always_comb begin
    brk_state_e nxt;
    logic       go_scan;
    nxt           = brk_q;
    go_scan       = 1'b0;
    state_d       = state_q;
    brk_d         = brk_q;
    cmd_d         = cmd_q;
    res_allowed_d = res_allowed_q;
    res_changed_d = res_changed_q;
    res_tripped_d = res_tripped_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_allowed_d = out_allowed_q;
    out_state_d   = out_state_q;
    out_changed_d = out_changed_q;
    out_tripped_d = out_tripped_q;
    dp_cmd_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d            = in_command_i;
          dp_cmd_o.capture = 1'b1;
          state_d          = S_EVAL;
        end
      end
      S_EVAL: begin
        res_allowed_d = 1'b0;
        res_tripped_d = 1'b0;
        unique case (cmd_q)
          CMD_REQUEST: begin
            if (brk_q == BRK_OPEN && dp_stat_i.timeout) begin
              nxt                  = BRK_HALF;
              dp_cmd_o.probe_first = 1'b1;
              dp_cmd_o.clr_success = 1'b1;
              res_allowed_d        = dp_stat_i.probe_lim_nz;
            end else if (brk_q == BRK_CLOSED) begin
              res_allowed_d = 1'b1;
            end else if (brk_q == BRK_HALF && dp_stat_i.probe_ok) begin
              dp_cmd_o.inc_probes = 1'b1;
              res_allowed_d       = 1'b1;
            end
          end
          CMD_SUCCESS: begin
            dp_cmd_o.inc_success = 1'b1;
            if (brk_q == BRK_HALF && dp_stat_i.succ_done) begin
              nxt                  = BRK_CLOSED;
              dp_cmd_o.clr_failure = 1'b1;
              dp_cmd_o.clr_success = 1'b1;
              dp_cmd_o.clr_probes  = 1'b1;
            end else if (brk_q == BRK_OPEN) begin
              nxt = BRK_CLOSED;
            end
          end
          CMD_FAILURE: begin
            dp_cmd_o.push_failure = 1'b1;
            if (brk_q == BRK_CLOSED) begin
              if (dp_stat_i.fail_lim) begin
                nxt           = BRK_OPEN;
                res_tripped_d = 1'b1;
              end else begin
                go_scan             = 1'b1;
                dp_cmd_o.scan_start = 1'b1;
              end
            end else if (brk_q == BRK_HALF) begin
              nxt                 = BRK_OPEN;
              dp_cmd_o.clr_probes = 1'b1;
            end else if (brk_q == BRK_OPEN && dp_stat_i.timeout) begin
              nxt                  = BRK_HALF;
              dp_cmd_o.clr_probes  = 1'b1;
              dp_cmd_o.clr_success = 1'b1;
            end
          end
          default: ;
        endcase
        res_changed_d        = (nxt != brk_q);
        dp_cmd_o.set_changed = (nxt != brk_q);
        brk_d                = nxt;
        state_d              = go_scan ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (dp_stat_i.scan_done) begin
          if (dp_stat_i.rate_trip) begin
            brk_d                = BRK_OPEN;
            res_tripped_d        = 1'b1;
            res_changed_d        = 1'b1;
            dp_cmd_o.set_changed = 1'b1;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_allowed_d = res_allowed_q;
          out_state_d   = brk_q;
          out_changed_d = res_changed_q;
          out_tripped_d = res_tripped_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      brk_q         <= BRK_CLOSED;
      cmd_q         <= CMD_REQUEST;
      res_allowed_q <= 1'b0;
      res_changed_q <= 1'b0;
      res_tripped_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_allowed_q <= 1'b0;
      out_state_q   <= BRK_CLOSED;
      out_changed_q <= 1'b0;
      out_tripped_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      brk_q         <= brk_d;
      cmd_q         <= cmd_d;
      res_allowed_q <= res_allowed_d;
      res_changed_q <= res_changed_d;
      res_tripped_q <= res_tripped_d;
      out_valid_q   <= out_valid_d;
      out_allowed_q <= out_allowed_d;
      out_state_q   <= out_state_d;
      out_changed_q <= out_changed_d;
      out_tripped_q <= out_tripped_d;
    end
  end

  a_trip_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_tripped_q |-> out_state_q == BRK_OPEN && out_changed_q)
    else $error("tripped result without a change to open");

  a_no_allow_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_allowed_q |-> out_state_q != BRK_OPEN)
    else $error("request allowed while open");

  a_scan_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat_i.scan_done |-> state_q == S_SCAN)
    else $error("scan finished outside the scan state");

  a_scan_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && !dp_stat_i.scan_done |=> state_q == S_SCAN)
    else $error("scan state left before the scan finished");

endmodule

>>> hdl/circuit_breaker_fsm_top.sv
// Top level of the closed, open and half-open circuit breaker.
// Each request on req_i is an admission request or a success or failure report with
// a millisecond time stamp; each request yields exactly one result on rsp_o carrying
// the allow flag, the breaker state after the request, and change and trip flags.
// Channels use valid and ready; a request is taken when both are high.
// The APB port holds the six configuration registers at byte addresses 0 to 20; the
// user must write it only while the block is idle, as the block does not enforce this.
// Requests, success reports and failure reports outside the closed state go from
// acceptance through the evaluation and output states to a registered result. A
// failure report in the closed state that does not reach the count limit walks the
// failure history memory one entry a cycle, counts the entries inside the window
// and compares that count with the rate limit before the result. One request is in
// work at a time; the next one is taken only once the block is back in idle.
// Reset restores the register defaults and a closed breaker with cleared counters;
// the history needs no clearing pass, since only written entries are scanned.
// When the receiver stalls, the result holds in the output register, one more request
// is accepted and evaluated, and the block then waits until the output is taken.
module circuit_breaker_fsm_top import cbf_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cbf_in_if.sink            req_i,
  cbf_out_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign pready = 1'b1;

  cbf_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  cbf_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .now_i  (req_i.now_ms),
    .cmd_i  (dp_cmd),
    .stat_o (dp_stat)
  );

  cbf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .in_command_i    (req_i.command),
    .dp_cmd_o        (dp_cmd),
    .dp_stat_i       (dp_stat),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .allowed_o       (rsp_o.allowed),
    .circuit_state_o (rsp_o.circuit_state),
    .state_changed_o (rsp_o.state_changed),
    .tripped_o       (rsp_o.tripped)
  );

endmodule
